[design/touch_gesture_event_detector_defines.svh]
// Assertion macros used by the touch gesture event detector top module.
// Each macro expects clk and rst to be visible in the including scope.
`ifndef TOUCH_GESTURE_EVENT_DETECTOR_DEFINES_SVH
`define TOUCH_GESTURE_EVENT_DETECTOR_DEFINES_SVH

// Check that a condition holds at every edge outside reset
`define TGED_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a same-cycle implication outside reset
`define TGED_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

[design/tged_pkg.sv]
package tged_pkg;

  // Configuration register widths
  localparam int THR_W = 13;
  localparam int RC_W  = 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_CONFIRM = 2'd1;

  // Reset values of the configuration registers
  localparam logic [THR_W-1:0] MOVE_THRESHOLD_RST  = 13'd10;
  localparam logic [RC_W-1:0]  RELEASE_CONFIRM_RST = 8'd3;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_DOWN = 2'd1,
    EV_MOVE = 2'd2,
    EV_UP   = 2'd3
  } ev_kind_t;

  typedef struct packed {
    logic [THR_W-1:0] move_threshold;
    logic [RC_W-1:0]  release_confirm;
  } tged_cfg_t;

endpackage

[design/tged_cfg.sv]
module tged_cfg
  import tged_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data,
  output tged_cfg_t            cfg
);

  // Always able to take a register write
  assign cfg_ready = 1'b1;

  // Decode the index and update the addressed register; ignore other indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.move_threshold  <= MOVE_THRESHOLD_RST;
      cfg.release_confirm <= RELEASE_CONFIRM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MOVE_THRESHOLD:  cfg.move_threshold  <= cfg_data;
        CFG_RELEASE_CONFIRM: cfg.release_confirm <= cfg_data[RC_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[design/tged_eval.sv]
module tged_eval
  import tged_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  tged_cfg_t                     cfg,
  // current tracking state
  input  logic                          touching,
  input  logic [RC_W-1:0]               release_count,
  input  logic [COORD_BITS-1:0]         last_x,
  input  logic [COORD_BITS-1:0]         last_y,
  input  logic [COORD_BITS-1:0]         ref_x,
  input  logic [COORD_BITS-1:0]         ref_y,
  // sample
  input  logic                          pressed,
  input  logic [COORD_BITS-1:0]         sx,
  input  logic [COORD_BITS-1:0]         sy,
  // next tracking state
  output logic                          touching_next,
  output logic [RC_W-1:0]               release_count_next,
  output logic [COORD_BITS-1:0]         last_x_next,
  output logic [COORD_BITS-1:0]         last_y_next,
  output logic [COORD_BITS-1:0]         ref_x_next,
  output logic [COORD_BITS-1:0]         ref_y_next,
  // event
  output ev_kind_t                      kind,
  output logic [COORD_BITS-1:0]         ev_x,
  output logic [COORD_BITS-1:0]         ev_y,
  output logic signed [COORD_BITS:0]    dx,
  output logic signed [COORD_BITS:0]    dy
);

  localparam int DIST_W = COORD_BITS + 1;
  localparam int CMP_W  = (DIST_W > THR_W) ? DIST_W : THR_W;

  logic signed [COORD_BITS:0] diff_x;
  logic signed [COORD_BITS:0] diff_y;
  logic [COORD_BITS-1:0]      mag_x;
  logic [COORD_BITS-1:0]      mag_y;
  logic [DIST_W-1:0]          manhattan;
  logic                       move_hit;
  logic [RC_W-1:0]            rc_inc;
  logic                       up_hit;

  // Distance of the sample from the move reference
  always_comb begin
    diff_x = $signed({1'b0, sx}) - $signed({1'b0, ref_x});
    diff_y = $signed({1'b0, sy}) - $signed({1'b0, ref_y});
    mag_x  = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
    mag_y  = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
    manhattan = DIST_W'(mag_x) + DIST_W'(mag_y);
    move_hit = CMP_W'(manhattan) >= CMP_W'(cfg.move_threshold);
    rc_inc = release_count + RC_W'(1);
    up_hit = rc_inc >= cfg.release_confirm;
  end

  // Pick the event in priority order: down, move, up
  always_comb begin
    touching_next      = touching;
    release_count_next = release_count;
    last_x_next        = last_x;
    last_y_next        = last_y;
    ref_x_next         = ref_x;
    ref_y_next         = ref_y;
    kind               = EV_NONE;
    ev_x               = '0;
    ev_y               = '0;
    dx                 = '0;
    dy                 = '0;
    if (pressed) begin
      last_x_next        = sx;
      last_y_next        = sy;
      release_count_next = '0;
      if (!touching) begin
        touching_next = 1'b1;
        ref_x_next    = sx;
        ref_y_next    = sy;
        kind          = EV_DOWN;
        ev_x          = sx;
        ev_y          = sy;
      end else if (move_hit) begin
        ref_x_next = sx;
        ref_y_next = sy;
        kind       = EV_MOVE;
        ev_x       = sx;
        ev_y       = sy;
        dx         = diff_x;
        dy         = diff_y;
      end
    end else if (touching) begin
      release_count_next = rc_inc;
      if (up_hit) begin
        touching_next      = 1'b0;
        release_count_next = '0;
        kind               = EV_UP;
        ev_x               = last_x;
        ev_y               = last_y;
      end
    end
  end

endmodule

[design/touch_gesture_event_detector.sv]
// Touch gesture event detector: takes one touch sample per item (touch_valid,
// sample_x, sample_y) and returns exactly one result item per sample with
// event_kind none, down, move or up, the event point and, for a move, the
// signed displacement from the previous reference point. A sample passes
// through an input register and one combinational evaluation into the result
// register, the tracking state being updated as it moves there; a new sample
// is taken every cycle unless out_stall holds the result register. The user
// must write move_threshold (index 0) and release_confirm (index 1) through
// the cfg port, always ready, only while no samples are in flight (not enforced).
module touch_gesture_event_detector
  import tged_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  // sample channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       touch_valid,
  input  logic [COORD_BITS-1:0]      sample_x,
  input  logic [COORD_BITS-1:0]      sample_y,
  // event channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 event_kind,
  output logic [COORD_BITS-1:0]      event_x,
  output logic [COORD_BITS-1:0]      event_y,
  output logic signed [COORD_BITS:0] delta_x,
  output logic signed [COORD_BITS:0] delta_y,
  // configuration channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [THR_W-1:0]           cfg_data
);

`include "touch_gesture_event_detector_defines.svh"

  tged_cfg_t cfg;

  // input register
  logic                  s1_valid;
  logic                  s1_pressed;
  logic [COORD_BITS-1:0] s1_x;
  logic [COORD_BITS-1:0] s1_y;

  // tracking state
  logic                  touching;
  logic [RC_W-1:0]       release_count;
  logic [COORD_BITS-1:0] last_x;
  logic [COORD_BITS-1:0] last_y;
  logic [COORD_BITS-1:0] ref_x;
  logic [COORD_BITS-1:0] ref_y;

  logic                  touching_next;
  logic [RC_W-1:0]       release_count_next;
  logic [COORD_BITS-1:0] last_x_next;
  logic [COORD_BITS-1:0] last_y_next;
  logic [COORD_BITS-1:0] ref_x_next;
  logic [COORD_BITS-1:0] ref_y_next;

  ev_kind_t                   kind;
  logic [COORD_BITS-1:0]      ev_x;
  logic [COORD_BITS-1:0]      ev_y;
  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;

  logic out_free;
  logic in_take;
  logic s1_move;

  tged_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tged_eval #(
    .COORD_BITS (COORD_BITS)
  ) u_eval (
    .cfg                (cfg),
    .touching           (touching),
    .release_count      (release_count),
    .last_x             (last_x),
    .last_y             (last_y),
    .ref_x              (ref_x),
    .ref_y              (ref_y),
    .pressed            (s1_pressed),
    .sx                 (s1_x),
    .sy                 (s1_y),
    .touching_next      (touching_next),
    .release_count_next (release_count_next),
    .last_x_next        (last_x_next),
    .last_y_next        (last_y_next),
    .ref_x_next         (ref_x_next),
    .ref_y_next         (ref_y_next),
    .kind               (kind),
    .ev_x               (ev_x),
    .ev_y               (ev_y),
    .dx                 (dx),
    .dy                 (dy)
  );

  // Handshake: result register frees up when empty or being taken
  assign out_free = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Capture the incoming item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pressed <= touch_valid;
      s1_x       <= sample_x;
      s1_y       <= sample_y;
    end
  end

  // Advance the tracking state as the item moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      touching      <= 1'b0;
      release_count <= '0;
      last_x        <= '0;
      last_y        <= '0;
      ref_x         <= '0;
      ref_y         <= '0;
    end else if (s1_move) begin
      touching      <= touching_next;
      release_count <= release_count_next;
      last_x        <= last_x_next;
      last_y        <= last_y_next;
      ref_x         <= ref_x_next;
      ref_y         <= ref_y_next;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      event_kind <= kind;
      event_x    <= ev_x;
      event_y    <= ev_y;
      delta_x    <= dx;
      delta_y    <= dy;
    end
  end

  `TGED_ASSERT_IMPL(a_delta_only_move,
    out_valid && (event_kind != EV_MOVE), (delta_x == '0) && (delta_y == '0),
    "nonzero delta on a non-move event")
  `TGED_ASSERT_IMPL(a_down_on_rise, $rose(touching),
    out_valid && (event_kind == EV_DOWN), "touch started without a down event")
  `TGED_ASSERT_IMPL(a_up_on_fall, $fell(touching) && !$past(rst),
    out_valid && (event_kind == EV_UP), "touch ended without an up event")
  `TGED_ASSERT(a_idle_count_clear, touching || (release_count == '0),
    "release count nonzero while not touching")

endmodule
